/* sv/plrkf_pkg.sv */
// shared widths, reset values and register codes of the per-link range filter
`default_nettype none
package plrkf_pkg;

	localparam int ANCHOR_COUNT_DEF = 4;
	localparam int TAG_COUNT_DEF    = 64;

	localparam int MEAS_W     = 16;
	localparam int ANC_W      = 2;
	localparam int TAG_W      = 6;
	localparam int IN_W       = MEAS_W + ANC_W + TAG_W;
	localparam int LINK_AW    = ANC_W + TAG_W;
	localparam int LINK_DEPTH = 1 << LINK_AW;

	localparam int EST_W   = 32;
	localparam int FRAC_W  = 16;
	localparam int NOISE_W = 24;
	localparam int GAIN_W  = FRAC_W + 1;

	localparam logic [GAIN_W-1:0]  GAIN_ONE = GAIN_W'(1) << FRAC_W;
	localparam logic [NOISE_W-1:0] Q_RESET  = NOISE_W'(1180);
	localparam logic [NOISE_W-1:0] R_RESET  = NOISE_W'(35521);

	localparam int CFG_IDX_W = 1;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_PROCESS_NOISE     = 1'b0,
		REG_MEASUREMENT_NOISE = 1'b1
	} cfg_reg_t;

endpackage
`default_nettype wire

/* sv/plrkf_div.sv */
// restoring divider for the gain, one quotient bit per cycle
`default_nettype none
module plrkf_div (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             start,
	input  wire logic [plrkf_pkg::EST_W-1:0]      num,
	input  wire logic [plrkf_pkg::EST_W:0]        den,
	output logic                                  done,
	output logic [plrkf_pkg::GAIN_W-1:0]          quot
);
	localparam int CW = $clog2(plrkf_pkg::GAIN_W);
	localparam int RW = plrkf_pkg::EST_W + 2;

	logic                          busy_q;
	logic                          done_q;
	logic [CW-1:0]                 cnt_q;
	logic [RW-1:0]                 rem_q;
	logic [plrkf_pkg::EST_W:0]     den_q;
	logic                          zero_q;
	logic [plrkf_pkg::GAIN_W-1:0]  quot_q;
	logic [RW-1:0]                 trial;
	logic [RW-1:0]                 den_ext;
	logic                          fit;
	logic                          last;

	// first step takes the numerator as is, later steps shift a zero in
	assign trial   = (cnt_q == '0) ? rem_q : {rem_q[RW-2:0], 1'b0};
	assign den_ext = {1'b0, den_q};
	assign fit     = trial >= den_ext;
	assign last    = cnt_q == CW'(plrkf_pkg::GAIN_W - 1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + CW'(1);
				if (last) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q  <= {2'b00, num};
			den_q  <= den;
			zero_q <= den == '0;
		end else if (busy_q) begin
			rem_q  <= fit ? (trial - den_ext) : trial;
			quot_q <= {quot_q[plrkf_pkg::GAIN_W-2:0], fit};
		end
	end

	assign done = done_q;
	assign quot = zero_q ? '0 : quot_q;

endmodule
`default_nettype wire

/* sv/plrkf_mul.sv */
// shift-and-add multiplier, one multiplier bit per cycle, result scaled down by the fraction
`default_nettype none
module plrkf_mul (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             start,
	input  wire logic [plrkf_pkg::GAIN_W-1:0]     mplr,
	input  wire logic [plrkf_pkg::EST_W-1:0]      mcand,
	output logic                                  done,
	output logic [plrkf_pkg::EST_W-1:0]           prod
);
	localparam int CW = $clog2(plrkf_pkg::GAIN_W);
	localparam int EW = plrkf_pkg::EST_W;
	localparam int GW = plrkf_pkg::GAIN_W;

	logic          busy_q;
	logic          done_q;
	logic [CW-1:0] cnt_q;
	logic [EW-1:0] hi_q;
	logic [GW-1:0] lo_q;
	logic [EW-1:0] mcand_q;
	logic [EW:0]   sum;

	assign sum = {1'b0, hi_q} + (lo_q[0] ? {1'b0, mcand_q} : '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + CW'(1);
				if (cnt_q == CW'(GW - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			hi_q    <= '0;
			lo_q    <= mplr;
			mcand_q <= mcand;
		end else if (busy_q) begin
			hi_q <= sum[EW:1];
			lo_q <= {sum[0], lo_q[GW-1:1]};
		end
	end

	// product is {hi, lo}; dropping the fraction and keeping 32 bits leaves hi[30:0] and the top bit of lo
	assign done = done_q;
	assign prod = {hi_q[EW-2:0], lo_q[GW-1]};

endmodule
`default_nettype wire

/* sv/per_link_range_kalman_filter.sv */
// per-link scalar kalman range filter: top level with link table and sequencer
//
// input words carry a range sample and the anchor and tag of its link; each
// word gives exactly one output word, the link's new estimate in Q16.16.
// a link out of the configured anchor or tag count returns zero and leaves
// the table untouched. one word is worked on at a time: an in-range word
// passes the link read, the prep, the bit-serial gain divider and the
// bit-serial multipliers that follow it; an out-of-range word goes
// straight to the result. the next word is taken the cycle after the result
// is loaded, so no new word is taken before the last one is through.
// s_tready is high while the sequencer is idle, also while a result still
// waits in the output register; a stalled receiver holds the next result in
// the sequencer until the output register frees.
// reset clears all link valid bits at once, so every link starts unset, and
// loads the noise registers with their default values; no sweep is needed.
// cfg writes are taken at any edge with cfg_we high, meant for idle periods.
`default_nettype none
module per_link_range_kalman_filter #(
	parameter int ANCHOR_COUNT = plrkf_pkg::ANCHOR_COUNT_DEF,
	parameter int TAG_COUNT    = plrkf_pkg::TAG_COUNT_DEF
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                s_tvalid,
	output logic                                     s_tready,
	// measurement [15:0], anchor_index [17:16], tag_index [23:18]
	input  wire logic [plrkf_pkg::IN_W-1:0]          s_tdata,
	output logic                                     m_tvalid,
	input  wire logic                                m_tready,
	// estimate [31:0]
	output logic [plrkf_pkg::EST_W-1:0]              m_tdata,
	input  wire logic                                cfg_we,
	input  wire logic [plrkf_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  wire logic [plrkf_pkg::NOISE_W-1:0]       cfg_data
);
	localparam int EW = plrkf_pkg::EST_W;
	localparam int MW = plrkf_pkg::MEAS_W;
	localparam int AW = plrkf_pkg::LINK_AW;
	localparam int GW = plrkf_pkg::GAIN_W;

	typedef enum logic [7:0] {
		ST_IDLE = 8'b0000_0001,
		ST_READ = 8'b0000_0010,
		ST_PREP = 8'b0000_0100,
		ST_DEN  = 8'b0000_1000,
		ST_DIV  = 8'b0001_0000,
		ST_MUL  = 8'b0010_0000,
		ST_DONE = 8'b0100_0000,
		ST_SPARE = 8'b1000_0000
	} state_t;

	state_t state_q;

	logic [plrkf_pkg::NOISE_W-1:0] q_noise_q;
	logic [plrkf_pkg::NOISE_W-1:0] r_noise_q;

	logic [MW-1:0]           in_meas;
	logic [plrkf_pkg::ANC_W-1:0] in_anc;
	logic [plrkf_pkg::TAG_W-1:0] in_tag;
	logic                    in_range;
	logic                    in_fire;

	logic [MW-1:0]           meas_q;
	logic [AW-1:0]           addr_q;
	logic [EW-1:0]           m_val;

	logic [2*EW-1:0]         link_mem [plrkf_pkg::LINK_DEPTH];
	logic [plrkf_pkg::LINK_DEPTH-1:0] link_vld_q;
	logic [2*EW-1:0]         rd_q;
	logic                    rd_vld_q;
	logic                    mem_we;
	logic [2*EW-1:0]         mem_wdata;

	logic                    fresh;
	logic [EW-1:0]           x_sel;
	logic [EW-1:0]           c_sel;
	logic [EW:0]             p_sum;
	logic [EW:0]             den;
	logic [EW-1:0]           x_q;
	logic [EW-1:0]           p_q;
	logic [EW-1:0]           mag_q;
	logic                    ge_q;

	logic                    div_start;
	logic                    div_done;
	logic [GW-1:0]           gain;
	logic                    mul_start;
	logic                    mul_done;
	logic                    cov_done;
	logic [EW-1:0]           corr;
	logic [EW-1:0]           new_p;
	logic [EW-1:0]           new_x;

	logic [EW-1:0]           res_q;
	logic                    out_vld_q;
	logic [EW-1:0]           out_data_q;
	logic                    out_load;

	assign in_meas  = s_tdata[MW-1:0];
	assign in_anc   = s_tdata[MW +: plrkf_pkg::ANC_W];
	assign in_tag   = s_tdata[MW + plrkf_pkg::ANC_W +: plrkf_pkg::TAG_W];
	assign in_range = (32'(in_anc) < 32'(ANCHOR_COUNT)) && (32'(in_tag) < 32'(TAG_COUNT));
	assign s_tready = state_q == ST_IDLE;
	assign in_fire  = s_tvalid && s_tready;

	assign m_val = {meas_q, {plrkf_pkg::FRAC_W{1'b0}}};

	// an unset link or a stored estimate of zero both reload from the sample
	assign fresh = !rd_vld_q || (rd_q[EW-1:0] == '0);
	assign x_sel = fresh ? m_val : rd_q[EW-1:0];
	assign c_sel = fresh ? m_val : rd_q[2*EW-1:EW];
	assign p_sum = {1'b0, c_sel} + (EW + 1)'(q_noise_q);
	assign den   = {1'b0, p_q} + (EW + 1)'(r_noise_q);

	assign div_start = state_q == ST_DEN;
	assign mul_start = (state_q == ST_DIV) && div_done;

	plrkf_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (p_q),
		.den    (den),
		.done   (div_done),
		.quot   (gain)
	);

	plrkf_mul u_mul_corr (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start),
		.mplr   (gain),
		.mcand  (mag_q),
		.done   (mul_done),
		.prod   (corr)
	);

	plrkf_mul u_mul_cov (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start),
		.mplr   (plrkf_pkg::GAIN_ONE - gain),
		.mcand  (p_q),
		.done   (cov_done),
		.prod   (new_p)
	);

	// estimate moves toward the sample and never passes it
	assign new_x     = ge_q ? (x_q + corr) : (x_q - corr);
	assign mem_we    = (state_q == ST_MUL) && mul_done;
	assign mem_wdata = {new_p, new_x};
	assign out_load  = (state_q == ST_DONE) && (!out_vld_q || m_tready);

	// noise registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			q_noise_q <= plrkf_pkg::Q_RESET;
			r_noise_q <= plrkf_pkg::R_RESET;
		end else if (cfg_we) begin
			case (plrkf_pkg::cfg_reg_t'(cfg_index))
				plrkf_pkg::REG_PROCESS_NOISE:     q_noise_q <= cfg_data;
				plrkf_pkg::REG_MEASUREMENT_NOISE: r_noise_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_fire) state_q <= in_range ? ST_READ : ST_DONE;
				end
				ST_READ: state_q <= ST_PREP;
				ST_PREP: state_q <= ST_DEN;
				ST_DEN:  state_q <= ST_DIV;
				ST_DIV: begin
					if (div_done) state_q <= ST_MUL;
				end
				ST_MUL: begin
					if (mul_done) state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (out_load) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// link valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			link_vld_q <= '0;
		end else if (mem_we) begin
			link_vld_q[addr_q] <= 1'b1;
		end
	end

	// link table
	always_ff @(posedge clk) begin
		if (mem_we) link_mem[addr_q] <= mem_wdata;
		if (state_q == ST_READ) rd_q <= link_mem[addr_q];
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (in_fire) begin
			meas_q <= in_meas;
			addr_q <= {in_anc, in_tag};
			res_q  <= '0;
		end
		if (state_q == ST_READ) rd_vld_q <= link_vld_q[addr_q];
		if (state_q == ST_PREP) begin
			x_q  <= x_sel;
			p_q  <= p_sum[EW] ? '1 : p_sum[EW-1:0];
			ge_q <= m_val >= x_sel;
		end
		if (state_q == ST_DEN) mag_q <= ge_q ? (m_val - x_q) : (x_q - m_val);
		if (mem_we) res_q <= new_x;
		if (out_load) out_data_q <= res_q;
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (out_load) begin
			out_vld_q <= 1'b1;
		end else if (m_tready) begin
			out_vld_q <= 1'b0;
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata  = out_data_q;

`ifndef SYNTHESIS
	a_out_of_range_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(in_fire && !in_range) |=> (state_q == ST_DONE && res_q == '0))
		else $error("out-of-range word did not give a zero result");

	a_div_in_state: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> (state_q == ST_DIV))
		else $error("divider finished outside its state");

	a_gain_bound: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |=> (gain <= plrkf_pkg::GAIN_ONE))
		else $error("gain above one");

	a_mul_lockstep: assert property (@(posedge clk) disable iff (!arst_n)
		mul_done == cov_done)
		else $error("multipliers out of step");

	a_est_between: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> ((ge_q && new_x >= x_q && new_x <= m_val) ||
			(!ge_q && new_x <= x_q && new_x >= m_val)))
		else $error("new estimate outside old estimate and sample");
`endif

endmodule
`default_nettype wire

/* sim/per_link_range_kalman_filter_tb.sv */
// self-checking testbench for the per-link range kalman filter with its own link table model
`timescale 1ns / 1ps
module per_link_range_kalman_filter_tb;

	localparam int  HALF_PERIOD = 6;
	localparam int  HOLD_CYCLES = 400;
	localparam int  DRAIN_CYCLES = 50;
	localparam longint CYCLE_LIMIT = 1000000;
	localparam int  HOT_LINKS = 8;

	localparam int  IN_W    = plrkf_pkg::IN_W;
	localparam int  EST_W   = plrkf_pkg::EST_W;
	localparam int  NOISE_W = plrkf_pkg::NOISE_W;
	localparam int  MEAS_W  = plrkf_pkg::MEAS_W;
	localparam int  ANC_W   = plrkf_pkg::ANC_W;
	localparam int  TAG_W   = plrkf_pkg::TAG_W;
	localparam int  FRAC_W  = plrkf_pkg::FRAC_W;
	localparam int  DEPTH   = plrkf_pkg::LINK_DEPTH;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 s_tvalid = 1'b0;
	logic                 s_tready;
	// measurement [15:0], anchor_index [17:16], tag_index [23:18]
	logic [IN_W-1:0]      s_tdata = '0;
	logic                 m_tvalid;
	logic                 m_tready = 1'b0;
	// estimate [31:0]
	logic [EST_W-1:0]     m_tdata;
	logic                 cfg_we = 1'b0;
	logic [plrkf_pkg::CFG_IDX_W-1:0] cfg_index = plrkf_pkg::REG_PROCESS_NOISE;
	logic [NOISE_W-1:0]   cfg_data = '0;

	// model copy of the link table and the noise registers
	logic [EST_W-1:0]     range_table [DEPTH];
	logic [EST_W-1:0]     cov_table [DEPTH];
	logic [NOISE_W-1:0]   noise_q = plrkf_pkg::Q_RESET;
	logic [NOISE_W-1:0]   noise_r = plrkf_pkg::R_RESET;

	logic [EST_W-1:0]     pending_estimates [$];
	int                   fail_count = 0;
	longint               cycle_count = 0;

	// sender and receiver idling controls
	bit                   tx_idle_en = 1'b1;
	logic                 rx_idle_en = 1'b1;
	logic                 hold_toggle = 1'b0;
	logic                 hold_seen = 1'b0;
	int                   hold_left = 0;
	int                   rx_stall = 0;

	logic [ANC_W-1:0]     hot_anc [HOT_LINKS];
	logic [TAG_W-1:0]     hot_tag [HOT_LINKS];
	logic [MEAS_W-1:0]    hot_meas [HOT_LINKS];

	per_link_range_kalman_filter DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #HALF_PERIOD clk = ~clk;

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	function automatic int pick_gap();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 45)
			return 0;
		if (roll < 85)
			return $urandom_range(1, 3);
		if (roll < 97)
			return $urandom_range(4, 20);
		return $urandom_range(40, 150);
	endfunction

	// one filter step on the model table, returns the link's new estimate
	function automatic logic [EST_W-1:0] filter_range(logic [MEAS_W-1:0] meas,
			logic [ANC_W-1:0] anc, logic [TAG_W-1:0] tag);
		logic [63:0] m, x, p, denom, gain;
		int link;
		if (int'(anc) >= plrkf_pkg::ANCHOR_COUNT_DEF ||
				int'(tag) >= plrkf_pkg::TAG_COUNT_DEF)
			return '0;
		link = int'(anc) * plrkf_pkg::TAG_COUNT_DEF + int'(tag);
		m = {32'b0, meas, 16'b0};
		// zero estimate marks an unset link: load it with the sample
		if (range_table[link] == '0) begin
			range_table[link] = m[31:0];
			cov_table[link] = m[31:0];
		end
		x = {32'b0, range_table[link]};
		p = {32'b0, cov_table[link]} + {40'b0, noise_q};
		if (p > 64'hFFFF_FFFF)
			p = 64'hFFFF_FFFF;
		denom = p + {40'b0, noise_r};
		gain = (denom == 0) ? 64'd0 : (p << FRAC_W) / denom;
		if (m >= x)
			x = x + ((gain * (m - x)) >> FRAC_W);
		else
			x = x - ((gain * (x - m)) >> FRAC_W);
		p = (((64'd1 << FRAC_W) - gain) * p) >> FRAC_W;
		range_table[link] = x[31:0];
		cov_table[link] = p[31:0];
		return x[31:0];
	endfunction

	// called just after a rising edge; valid stays high for a back-to-back word
	task automatic send_sample(input logic [MEAS_W-1:0] meas, input logic [ANC_W-1:0] anc,
			input logic [TAG_W-1:0] tag);
		int gap;
		gap = tx_idle_en ? pick_gap() : 0;
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {tag, anc, meas};
		do @(posedge clk); while (s_tready !== 1'b1);
		pending_estimates.push_back(filter_range(meas, anc, tag));
	endtask

	task automatic wait_idle();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (pending_estimates.size() != 0);
	endtask

	task automatic write_reg(input plrkf_pkg::cfg_reg_t idx,
			input logic [NOISE_W-1:0] value);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == plrkf_pkg::REG_PROCESS_NOISE)
			noise_q = value;
		else
			noise_r = value;
		@(posedge clk);
	endtask

	task automatic set_noise(input logic [NOISE_W-1:0] q, input logic [NOISE_W-1:0] r);
		wait_idle();
		write_reg(plrkf_pkg::REG_PROCESS_NOISE, q);
		write_reg(plrkf_pkg::REG_MEASUREMENT_NOISE, r);
	endtask

	// reset defaults: unset links, field extremes, zero sample leaving a link unset
	task automatic test_first_samples();
		send_sample(16'd0, 2'd0, 6'd0);
		send_sample(16'hFFFF, 2'd3, 6'd63);
		send_sample(16'd0, 2'd3, 6'd63);
		send_sample(16'h5555, 2'd1, 6'd42);
		send_sample(16'hAAAA, 2'd2, 6'd21);
		send_sample(16'hAAAA, 2'd1, 6'd42);
		send_sample(16'd1234, 2'd0, 6'd0);
		send_sample(16'd1235, 2'd0, 6'd0);
	endtask

	// largest noise: predicted covariance clips at all ones
	task automatic test_covariance_saturation();
		set_noise(24'hFF_FFFF, 24'hFF_FFFF);
		send_sample(16'hFFFF, 2'd3, 6'd0);
		send_sample(16'hFFFF, 2'd3, 6'd0);
		send_sample(16'd1, 2'd3, 6'd0);
		send_sample(16'hFFFE, 2'd3, 6'd1);
		send_sample(16'd0, 2'd3, 6'd1);
	endtask

	// no noise at all: zero denominator keeps the estimate
	task automatic test_zero_noise();
		set_noise(24'd0, 24'd0);
		send_sample(16'd0, 2'd1, 6'd1);
		send_sample(16'd100, 2'd1, 6'd2);
		send_sample(16'd200, 2'd1, 6'd2);
	endtask

	// full gain drags an estimate to zero, the link then reloads
	task automatic test_estimate_to_zero();
		set_noise(24'd1, 24'd0);
		send_sample(16'd50, 2'd1, 6'd3);
		send_sample(16'd0, 2'd1, 6'd3);
		send_sample(16'd77, 2'd1, 6'd3);
		send_sample(16'd78, 2'd1, 6'd3);
	endtask

	// receiver holds off long enough for the input side to stall
	task automatic test_output_backpressure();
		int i;
		set_noise(plrkf_pkg::Q_RESET, plrkf_pkg::R_RESET);
		tx_idle_en = 1'b0;
		hold_toggle <= ~hold_toggle;
		for (i = 0; i < 12; i++)
			send_sample(16'($urandom), 2'($urandom), 6'($urandom));
		tx_idle_en = 1'b1;
	endtask

	// mostly repeated samples on a few busy links, some noise across the table
	task automatic test_random_traffic(input int count, input logic [NOISE_W-1:0] q,
			input logic [NOISE_W-1:0] r, input bit with_idle);
		int i, k, roll;
		logic [MEAS_W-1:0] meas;
		set_noise(q, r);
		tx_idle_en = with_idle;
		rx_idle_en <= with_idle;
		for (k = 0; k < HOT_LINKS; k++) begin
			hot_anc[k] = 2'($urandom);
			hot_tag[k] = 6'($urandom);
			hot_meas[k] = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 40))
				: 16'($urandom);
		end
		for (i = 0; i < count; i++) begin
			roll = $urandom_range(0, 99);
			if (roll < 70) begin
				k = $urandom_range(0, HOT_LINKS - 1);
				meas = hot_meas[k] + 16'($urandom_range(0, 64)) - 16'd32;
				if ($urandom_range(0, 9) == 0)
					meas = ($urandom_range(0, 1) == 1) ? 16'd0 : 16'($urandom);
				send_sample(meas, hot_anc[k], hot_tag[k]);
			end else if (roll < 80) begin
				meas = ($urandom_range(0, 1) == 1) ? 16'hFFFF : 16'd0;
				send_sample(meas, 2'($urandom), 6'($urandom));
			end else begin
				send_sample(16'($urandom), 2'($urandom), 6'($urandom));
			end
		end
		tx_idle_en = 1'b1;
		rx_idle_en <= 1'b1;
	endtask

	// result checker and receiver stall generator
	always @(posedge clk) begin : rx_side
		logic [EST_W-1:0] want;
		if (arst_n && m_tvalid === 1'b1 && m_tready) begin
			if (pending_estimates.size() == 0) begin
				$error("unexpected result word: estimate actual %0h", m_tdata);
				fail_count++;
			end else begin
				want = pending_estimates.pop_front();
				if (m_tdata !== want) begin
					$error("estimate mismatch: expected %0h actual %0h", want, m_tdata);
					fail_count++;
				end
			end
		end
		if (hold_toggle != hold_seen) begin
			hold_seen = hold_toggle;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else if (rx_stall > 0) begin
			rx_stall--;
			m_tready <= 1'b0;
		end else if (rx_idle_en && $urandom_range(0, 9) == 0) begin
			rx_stall = pick_gap();
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
		end
	end

	initial begin
		int i;
		for (i = 0; i < DEPTH; i++) begin
			range_table[i] = '0;
			cov_table[i] = '0;
		end
		arst_n = 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_first_samples();
		test_covariance_saturation();
		test_zero_noise();
		test_estimate_to_zero();
		test_output_backpressure();
		test_random_traffic(125, plrkf_pkg::Q_RESET, plrkf_pkg::R_RESET, 1'b1);
		test_random_traffic(125, 24'd0, 24'hFF_FFFF, 1'b1);
		test_random_traffic(125, 24'hFF_FFFF, 24'd0, 1'b0);
		test_random_traffic(125, 24'($urandom), 24'($urandom), 1'b1);
		test_random_traffic(125, 24'($urandom_range(0, 4096)), 24'($urandom_range(0, 65536)),
			1'b1);

		wait_idle();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

/* per_link_range_kalman_filter.f */
sv/plrkf_pkg.sv
sv/plrkf_div.sv
sv/plrkf_mul.sv
sv/per_link_range_kalman_filter.sv
sim/per_link_range_kalman_filter_tb.sv
